// ----- hdl/ahsp_pkg.sv -----
// ----------------------------------------------------------------------------
// ahsp_pkg
// Types, constants and tables shared by the angular hue shading pipeline.
// ----------------------------------------------------------------------------
package ahsp_pkg;

	localparam int MAX_DIM         = 1024;
	localparam int COORD_FRAC_BITS = 12;

	localparam int CFG_W  = 16;
	localparam int DVS_W  = 11;
	localparam int DIV_W  = 26;
	localparam int VEC_W  = 46;
	localparam int VZ_W   = 18;
	localparam int ANG_W  = 17;
	localparam int ROT_W  = 27;
	localparam int RZ_W   = 17;
	localparam int SHD_W  = 8;
	localparam int CH_W   = 17;
	localparam int ITERS  = 14;

	localparam logic signed [ANG_W-1:0] ANG_PI     = 17'sd32768;
	localparam logic signed [ANG_W-1:0] ANG_HALF   = 17'sd16384;
	localparam logic signed [ANG_W-1:0] ANG_SIXTH  = 17'sd5461;
	localparam logic signed [ANG_W-1:0] ANG_THIRD2 = 17'sd21845;
	localparam logic [ROT_W-1:0]        COS_GAIN   = 27'd10188014;
	localparam logic [24:0]             ONE_Q24    = 25'd16777216;
	localparam logic [15:0]             RECIP3     = 16'd43691;

	typedef enum logic [2:0] {
		CFG_LEFT,
		CFG_TOP,
		CFG_RIGHT,
		CFG_BOTTOM,
		CFG_COLS,
		CFG_ROWS
	} cfg_reg_t;

	typedef struct packed {
		logic [DIV_W-1:0] nu;
		logic [DIV_W-1:0] nv;
		logic [DVS_W-1:0] ru;
		logic [DVS_W-1:0] rv;
		logic             neg_u;
		logic             neg_v;
		logic [SHD_W-1:0] shade;
	} div_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [VZ_W-1:0]  z;
		logic                    spec;
		logic signed [ANG_W-1:0] sp_ang;
		logic signed [ANG_W-1:0] base;
		logic [SHD_W-1:0]        shade;
	} vec_t;

	typedef struct packed {
		logic [2:0][ROT_W-1:0] x;
		logic [2:0][ROT_W-1:0] y;
		logic [2:0][RZ_W-1:0]  z;
		logic [2:0]            zero;
		logic [SHD_W-1:0]      shade;
	} rot_t;

	function automatic logic [15:0] atan_val(input int i);
		logic [15:0] v;
		case (i)
			0:       v = 16'd8192;
			1:       v = 16'd4836;
			2:       v = 16'd2555;
			3:       v = 16'd1297;
			4:       v = 16'd651;
			5:       v = 16'd326;
			6:       v = 16'd163;
			7:       v = 16'd81;
			8:       v = 16'd41;
			9:       v = 16'd20;
			10:      v = 16'd10;
			11:      v = 16'd5;
			12:      v = 16'd3;
			13:      v = 16'd1;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- hdl/ahsp_div_cell.sv -----
// ----------------------------------------------------------------------------
// ahsp_div_cell
// One restoring division step for the x and y lanes.
// ----------------------------------------------------------------------------
module ahsp_div_cell import ahsp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld_in,
	input  div_t             d_in,
	input  logic [DVS_W-1:0] du,
	input  logic [DVS_W-1:0] dv,
	output logic             vld_out,
	output div_t             d_out
);

	logic [DVS_W:0] tu, tv;
	logic           geu, gev;
	div_t           d_n;
	div_t           res_s1;
	logic           vld_s1;

	always_comb begin
		tu      = {d_in.ru, d_in.nu[DIV_W-1]};
		tv      = {d_in.rv, d_in.nv[DIV_W-1]};
		geu     = tu >= {1'b0, du};
		gev     = tv >= {1'b0, dv};
		d_n     = d_in;
		d_n.ru  = geu ? DVS_W'(tu - {1'b0, du}) : tu[DVS_W-1:0];
		d_n.rv  = gev ? DVS_W'(tv - {1'b0, dv}) : tv[DVS_W-1:0];
		d_n.nu  = {d_in.nu[DIV_W-2:0], geu};
		d_n.nv  = {d_in.nv[DIV_W-2:0], gev};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		res_s1 <= d_n;
	end

	assign vld_out = vld_s1;
	assign d_out   = res_s1;

endmodule

// ----- hdl/ahsp_vec_cell.sv -----
// ----------------------------------------------------------------------------
// ahsp_vec_cell
// One CORDIC vectoring micro-rotation for the angle of (x, y).
// ----------------------------------------------------------------------------
module ahsp_vec_cell import ahsp_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic vld_in,
	input  vec_t d_in,
	output logic vld_out,
	output vec_t d_out
);

	localparam logic signed [VZ_W-1:0] TAB = VZ_W'(atan_val(STEP));

	vec_t d_n;
	vec_t res_s1;
	logic vld_s1;

	always_comb begin
		d_n = d_in;
		if (!d_in.y[VEC_W-1] && (d_in.y != '0)) begin
			d_n.x = d_in.x + (d_in.y >>> STEP);
			d_n.y = d_in.y - (d_in.x >>> STEP);
			d_n.z = d_in.z + TAB;
		end else begin
			d_n.x = d_in.x - (d_in.y >>> STEP);
			d_n.y = d_in.y + (d_in.x >>> STEP);
			d_n.z = d_in.z - TAB;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		res_s1 <= d_n;
	end

	assign vld_out = vld_s1;
	assign d_out   = res_s1;

endmodule

// ----- hdl/ahsp_rot_cell.sv -----
// ----------------------------------------------------------------------------
// ahsp_rot_cell
// One CORDIC rotation micro-step for the three colour lanes.
// ----------------------------------------------------------------------------
module ahsp_rot_cell import ahsp_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic vld_in,
	input  rot_t d_in,
	output logic vld_out,
	output rot_t d_out
);

	localparam logic [RZ_W-1:0] TAB = RZ_W'(atan_val(STEP));

	rot_t d_n;
	rot_t res_s1;
	logic vld_s1;

	always_comb begin
		d_n = d_in;
		for (int k = 0; k < 3; k++) begin
			if (!d_in.z[k][RZ_W-1]) begin
				d_n.x[k] = $signed(d_in.x[k]) - ($signed(d_in.y[k]) >>> STEP);
				d_n.y[k] = $signed(d_in.y[k]) + ($signed(d_in.x[k]) >>> STEP);
				d_n.z[k] = d_in.z[k] - TAB;
			end else begin
				d_n.x[k] = $signed(d_in.x[k]) + ($signed(d_in.y[k]) >>> STEP);
				d_n.y[k] = $signed(d_in.y[k]) - ($signed(d_in.x[k]) >>> STEP);
				d_n.z[k] = d_in.z[k] + TAB;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		res_s1 <= d_n;
	end

	assign vld_out = vld_s1;
	assign d_out   = res_s1;

endmodule

// ----- hdl/angular_hue_shade_pixel_unit.sv -----
// ----------------------------------------------------------------------------
// angular_hue_shade_pixel_unit
// Per-pixel angular hue shading: world mapping, atan2, three cosine lobes.
//
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------
//  input    | start / busy        | pix_x, pix_y, shade
//  result   | done (strobe)       | red, green, blue
//  config   | cfg_valid/cfg_ready | cfg_addr, cfg_wdata
//
// One item per clock; busy stays low. The pipeline holds the
// 26-cell divider row and the two 14-cell CORDIC rows.
// Reset clears the pipeline valid bits and loads the register defaults.
// Results are strobed for one cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module angular_hue_shade_pixel_unit import ahsp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [9:0]       pix_x,
	input  logic [9:0]       pix_y,
	input  logic [SHD_W-1:0] shade,
	output logic             done,
	output logic [CH_W-1:0]  red,
	output logic [CH_W-1:0]  green,
	output logic [CH_W-1:0]  blue,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_addr,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam logic signed [27:0] HALF = 28'sd1 <<< (COORD_FRAC_BITS - 1);

	function automatic logic [DVS_W-1:0] clamp_div(input logic [DVS_W-1:0] r);
		logic [DVS_W-1:0] d;
		if (r == '0) begin
			d = DVS_W'(1);
		end else if (r > DVS_W'(MAX_DIM)) begin
			d = DVS_W'(MAX_DIM);
		end else begin
			d = r;
		end
		return d;
	endfunction

	function automatic logic signed [ANG_W-1:0] wrap_sub(
		input logic signed [ANG_W-1:0] a,
		input logic signed [ANG_W-1:0] c
	);
		logic signed [ANG_W:0] s;
		s = {a[ANG_W-1], a} - {c[ANG_W-1], c};
		if (s < -$signed({ANG_PI[ANG_W-1], ANG_PI})) begin
			s = s + 18'sd65536;
		end
		return s[ANG_W-1:0];
	endfunction

	// configuration
	logic signed [CFG_W-1:0] left_q, top_q, right_q, bottom_q;
	logic [DVS_W-1:0]        cols_q, rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			top_q    <= '0;
			right_q  <= 16'sd4096;
			bottom_q <= 16'sd4096;
			cols_q   <= 11'd1024;
			rows_q   <= 11'd1024;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_addr)
				CFG_LEFT:   left_q   <= cfg_wdata;
				CFG_TOP:    top_q    <= cfg_wdata;
				CFG_RIGHT:  right_q  <= cfg_wdata;
				CFG_BOTTOM: bottom_q <= cfg_wdata;
				CFG_COLS:   cols_q   <= cfg_wdata[DVS_W-1:0];
				CFG_ROWS:   rows_q   <= cfg_wdata[DVS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	logic [DVS_W-1:0] du, dv;
	assign du = clamp_div(cols_q);
	assign dv = clamp_div(rows_q);

	// s1: span times pixel index
	logic signed [CFG_W:0] wd, ht;
	logic signed [27:0]    nx_c, ny_c;
	logic signed [27:0]    nx_s1, ny_s1;
	logic [SHD_W-1:0]      shade_s1;
	logic                  vld_s1;

	assign wd   = {right_q[CFG_W-1], right_q} - {left_q[CFG_W-1], left_q};
	assign ht   = {bottom_q[CFG_W-1], bottom_q} - {top_q[CFG_W-1], top_q};
	assign nx_c = wd * $signed({1'b0, pix_x});
	assign ny_c = ht * $signed({1'b0, pix_y});

	// s2: floor division turned into unsigned division
	div_t div_c2;
	div_t div_s2;
	logic vld_s2;

	always_comb begin
		div_c2.neg_u = nx_s1[27];
		div_c2.neg_v = ny_s1[27];
		div_c2.nu    = nx_s1[27] ? DIV_W'(-nx_s1 + 28'(du) - 28'sd1) : DIV_W'(nx_s1);
		div_c2.nv    = ny_s1[27] ? DIV_W'(-ny_s1 + 28'(dv) - 28'sd1) : DIV_W'(ny_s1);
		div_c2.ru    = '0;
		div_c2.rv    = '0;
		div_c2.shade = shade_s1;
	end

	div_t div_c [DIV_W+1];
	logic vld_dc [DIV_W+1];

	assign div_c[0]  = div_s2;
	assign vld_dc[0] = vld_s2;

	for (genvar i = 0; i < DIV_W; i++) begin : g_div
		ahsp_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (vld_dc[i]),
			.d_in    (div_c[i]),
			.du      (du),
			.dv      (dv),
			.vld_out (vld_dc[i+1]),
			.d_out   (div_c[i+1])
		);
	end

	// s3: world coordinates
	div_t                div_e;
	logic signed [26:0]  qu, qv;
	logic signed [27:0]  u_s3, v_s3;
	logic [SHD_W-1:0]    shade_s3;
	logic                vld_s3;

	assign div_e = div_c[DIV_W];
	assign qu = div_e.neg_u ? -$signed({1'b0, div_e.nu}) : $signed({1'b0, div_e.nu});
	assign qv = div_e.neg_v ? -$signed({1'b0, div_e.nv}) : $signed({1'b0, div_e.nv});

	// s4: vectoring set-up for atan2(u, -v)
	logic signed [28:0] ya, xa, yf, xf;
	vec_t               vec_c4;
	vec_t               vec_s4;
	logic               vld_s4;

	always_comb begin
		ya            = 29'(u_s3);
		xa            = -29'(v_s3);
		vec_c4.spec   = 1'b0;
		vec_c4.sp_ang = '0;
		vec_c4.base   = '0;
		vec_c4.z      = '0;
		vec_c4.shade  = shade_s3;
		xf            = xa;
		yf            = ya;
		if (ya == '0) begin
			vec_c4.spec   = 1'b1;
			vec_c4.sp_ang = xa[28] ? ANG_PI : '0;
		end else if (xa == '0) begin
			vec_c4.spec   = 1'b1;
			vec_c4.sp_ang = ya[28] ? -ANG_HALF : ANG_HALF;
		end else if (xa[28]) begin
			vec_c4.base = ya[28] ? -ANG_PI : ANG_PI;
			xf          = -xa;
			yf          = -ya;
		end
		vec_c4.x = $signed({xf[28], xf, 16'b0});
		vec_c4.y = $signed({yf[28], yf, 16'b0});
	end

	vec_t vec_c [ITERS+1];
	logic vld_vc [ITERS+1];

	assign vec_c[0]  = vec_s4;
	assign vld_vc[0] = vld_s4;

	for (genvar i = 0; i < ITERS; i++) begin : g_vec
		ahsp_vec_cell #(.STEP(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (vld_vc[i]),
			.d_in    (vec_c[i]),
			.vld_out (vld_vc[i+1]),
			.d_out   (vec_c[i+1])
		);
	end

	// s5: angle with base and clamp
	vec_t                    vec_e;
	logic signed [VZ_W:0]    zs;
	logic signed [ANG_W-1:0] a_c5, a_s5;
	logic [SHD_W-1:0]        shade_s5;
	logic                    vld_s5;

	assign vec_e = vec_c[ITERS];

	always_comb begin
		zs = {vec_e.z[VZ_W-1], vec_e.z} + (VZ_W+1)'(vec_e.base);
		if (vec_e.spec) begin
			a_c5 = vec_e.sp_ang;
		end else if (zs > (VZ_W+1)'(ANG_PI)) begin
			a_c5 = ANG_PI;
		end else if (zs < -(VZ_W+1)'(ANG_PI)) begin
			a_c5 = -ANG_PI;
		end else begin
			a_c5 = zs[ANG_W-1:0];
		end
	end

	// s6: three phases (lane 0 red, 1 green, 2 blue)
	logic signed [ANG_W-1:0] g_c, r_c, b_c;
	logic signed [ANG_W-1:0] ph_s6 [3];
	logic [SHD_W-1:0]        shade_s6;
	logic                    vld_s6;

	assign g_c = wrap_sub(a_s5, ANG_SIXTH);
	assign r_c = wrap_sub(g_c, ANG_THIRD2);
	assign b_c = wrap_sub(r_c, ANG_THIRD2);

	// s7: phase * 2/3 and rotation set-up
	rot_t rot_c7;
	rot_t rot_s7;
	logic vld_s7;

	always_comb begin
		logic signed [ANG_W:0] n;
		logic [ANG_W-1:0]      mag;
		logic [32:0]           p;
		logic [15:0]           q;
		rot_c7.shade = shade_s6;
		for (int k = 0; k < 3; k++) begin
			n   = {ph_s6[k], 1'b0};
			mag = n[ANG_W] ? ANG_W'(-n) : ANG_W'(n);
			p   = 33'(mag) * 33'(RECIP3);
			q   = p[32:17];
			rot_c7.z[k]    = n[ANG_W] ? -RZ_W'(q) : RZ_W'(q);
			rot_c7.zero[k] = q >= 16'(ANG_HALF);
			rot_c7.x[k]    = COS_GAIN;
			rot_c7.y[k]    = '0;
		end
	end

	rot_t rot_c [ITERS+1];
	logic vld_rc [ITERS+1];

	assign rot_c[0]  = rot_s7;
	assign vld_rc[0] = vld_s7;

	for (genvar i = 0; i < ITERS; i++) begin : g_rot
		ahsp_rot_cell #(.STEP(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (vld_rc[i]),
			.d_in    (rot_c[i]),
			.vld_out (vld_rc[i+1]),
			.d_out   (rot_c[i+1])
		);
	end

	// s8: clamp and scale
	rot_t            rot_e;
	logic [16:0]     s384;
	logic [CH_W-1:0] ch_c [3];
	logic [CH_W-1:0] ch_s8 [3];
	logic            vld_s8;

	assign rot_e = rot_c[ITERS];
	assign s384  = {1'b0, rot_e.shade, 8'b0} + {2'b0, rot_e.shade, 7'b0};

	always_comb begin
		logic [24:0] c;
		logic [41:0] p;
		for (int k = 0; k < 3; k++) begin
			if (rot_e.zero[k] || rot_e.x[k][ROT_W-1]) begin
				c = '0;
			end else if (rot_e.x[k] > ROT_W'(ONE_Q24)) begin
				c = ONE_Q24;
			end else begin
				c = rot_e.x[k][24:0];
			end
			p       = 42'(s384) * 42'(c) + 42'd8388608;
			ch_c[k] = p[40:24];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_dc[DIV_W];
			vld_s4 <= vld_s3;
			vld_s5 <= vld_vc[ITERS];
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_rc[ITERS];
		end
	end

	always_ff @(posedge clk) begin
		nx_s1    <= nx_c;
		ny_s1    <= ny_c;
		shade_s1 <= shade;
		div_s2   <= div_c2;
		u_s3     <= 28'(left_q) - HALF + 28'(qu);
		v_s3     <= 28'(top_q) - HALF + 28'(qv);
		shade_s3 <= div_e.shade;
		vec_s4   <= vec_c4;
		a_s5     <= a_c5;
		shade_s5 <= vec_e.shade;
		ph_s6[0] <= r_c;
		ph_s6[1] <= g_c;
		ph_s6[2] <= b_c;
		shade_s6 <= shade_s5;
		rot_s7   <= rot_c7;
		ch_s8    <= ch_c;
	end

	assign done  = vld_s8;
	assign red   = ch_s8[0];
	assign green = ch_s8[1];
	assign blue  = ch_s8[2];

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_dc[DIV_W] |-> (div_e.ru < du) && (div_e.rv < dv))
		else $error("divider remainder not below divisor");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |-> (ph_s6[0] >= -ANG_PI) && (ph_s6[0] <= ANG_PI) &&
			(ph_s6[1] >= -ANG_PI) && (ph_s6[1] <= ANG_PI) &&
			(ph_s6[2] >= -ANG_PI) && (ph_s6[2] <= ANG_PI))
		else $error("phase outside wrap range");

	a_dark_lobe: assert property (@(posedge clk) disable iff (!arst_n)
		vld_rc[ITERS] && rot_e.zero[0] |=> done && (red == '0))
		else $error("red lane outside lobe not dark");

endmodule

// ----- test/angular_hue_shade_pixel_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angular_hue_shade_pixel_unit_tb
// Drives pixels through the hue shading unit under several frame settings
// and checks every red/green/blue result against a bit-exact predictor.
// ----------------------------------------------------------------------------
module angular_hue_shade_pixel_unit_tb import ahsp_pkg::*; ();

	typedef struct {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	class hue_scoreboard;
		longint left_q, top_q, right_q, bottom_q, cols_q, rows_q;
		longint atan_step[14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20,
			10, 5, 3, 1};
		rgb_t   pending_rgb[$];
		int     errors;

		function void reset_frame();
			left_q = 0; top_q = 0; right_q = 4096; bottom_q = 4096;
			cols_q = 1024; rows_q = 1024;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
			case (idx)
				CFG_LEFT:   left_q   = longint'($signed(val));
				CFG_TOP:    top_q    = longint'($signed(val));
				CFG_RIGHT:  right_q  = longint'($signed(val));
				CFG_BOTTOM: bottom_q = longint'($signed(val));
				CFG_COLS:   cols_q   = val[DVS_W-1:0];
				CFG_ROWS:   rows_q   = val[DVS_W-1:0];
				default: ;
			endcase
		endfunction

		function longint floor_div(longint n, longint d);
			longint q;
			q = n / d;
			if ((n % d) != 0 && n < 0) q--;
			return q;
		endfunction

		function longint clamp_dim(longint d);
			if (d == 0) return 1;
			if (d > MAX_DIM) return MAX_DIM;
			return d;
		endfunction

		function longint vector_angle(longint y, longint x);
			longint z, base, xo;
			z = 0; base = 0;
			if (y == 0) return x >= 0 ? 0 : 32768;
			if (x == 0) return y > 0 ? 16384 : -16384;
			if (x < 0) begin
				base = y > 0 ? 32768 : -32768;
				x = -x;
				y = -y;
			end
			x = x * 65536;
			y = y * 65536;
			for (int i = 0; i < ITERS; i++) begin
				xo = x;
				if (y > 0) begin
					x += y >>> i; y -= xo >>> i; z += atan_step[i];
				end else begin
					x -= y >>> i; y += xo >>> i; z -= atan_step[i];
				end
			end
			z += base;
			if (z > 32768) z = 32768;
			if (z < -32768) z = -32768;
			return z;
		endfunction

		function longint cos_lobe(longint a);
			longint x, y, z, xo;
			x = 10188014; y = 0; z = a;
			if (a >= 16384 || a <= -16384) return 0;
			for (int i = 0; i < ITERS; i++) begin
				xo = x;
				if (z >= 0) begin
					x -= y >>> i; y += xo >>> i; z -= atan_step[i];
				end else begin
					x += y >>> i; y -= xo >>> i; z += atan_step[i];
				end
			end
			if (x < 0) x = 0;
			if (x > 16777216) x = 16777216;
			return x;
		endfunction

		function logic [CH_W-1:0] lobe_level(longint phase, longint shd);
			longint p;
			p = shd * 384 * cos_lobe((2 * phase) / 3) + (longint'(1) << 23);
			return CH_W'(p >>> 24);
		endfunction

		function void note_pixel(longint px, longint py, longint shd);
			longint u, v, g, r, b;
			rgb_t   e;
			u = left_q - 2048 + floor_div((right_q - left_q) * px, clamp_dim(cols_q));
			v = top_q - 2048 + floor_div((bottom_q - top_q) * py, clamp_dim(rows_q));
			g = vector_angle(u, -v) - 5461;
			if (g < -32768) g += 65536;
			r = g - 21845;
			if (r < -32768) r += 65536;
			b = r - 21845;
			if (b < -32768) b += 65536;
			e.red = lobe_level(r, shd);
			e.green = lobe_level(g, shd);
			e.blue = lobe_level(b, shd);
			pending_rgb.push_back(e);
		endfunction

		function void check_pixel(rgb_t got);
			rgb_t e;
			if (pending_rgb.size() == 0) begin
				$display("%0t: unexpected result r=%0d g=%0d b=%0d", $time,
					got.red, got.green, got.blue);
				errors++;
				return;
			end
			e = pending_rgb.pop_front();
			if (got.red !== e.red) begin
				$display("%0t: red expected %0d actual %0d", $time, e.red, got.red);
				errors++;
			end
			if (got.green !== e.green) begin
				$display("%0t: green expected %0d actual %0d", $time, e.green, got.green);
				errors++;
			end
			if (got.blue !== e.blue) begin
				$display("%0t: blue expected %0d actual %0d", $time, e.blue, got.blue);
				errors++;
			end
		endfunction
	endclass

	logic             clk, arst_n, start, busy, done, cfg_valid, cfg_ready;
	logic [9:0]       pix_x, pix_y;
	logic [SHD_W-1:0] shade;
	logic [CH_W-1:0]  red, green, blue;
	logic [2:0]       cfg_addr;
	logic [CFG_W-1:0] cfg_wdata;
	longint           cycles;
	hue_scoreboard    sb;

	angular_hue_shade_pixel_unit dut (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		rgb_t got;
		if (arst_n && done) begin
			got.red = red; got.green = green; got.blue = blue;
			sb.check_pixel(got);
		end
	end

	task automatic cfg_write(cfg_reg_t idx, logic [CFG_W-1:0] val);
		logic acc;
		cfg_valid <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		do begin
			@(negedge clk);
			acc = cfg_ready;
			@(posedge clk);
		end while (!acc);
		sb.set_reg(idx, val);
	endtask

	task automatic set_frame(logic [15:0] l, logic [15:0] t, logic [15:0] r,
			logic [15:0] b, logic [15:0] c, logic [15:0] rw);
		cfg_write(CFG_LEFT, l);
		cfg_write(CFG_TOP, t);
		cfg_write(CFG_RIGHT, r);
		cfg_write(CFG_BOTTOM, b);
		cfg_write(CFG_COLS, c);
		cfg_write(CFG_ROWS, rw);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_pixel(logic [9:0] px, logic [9:0] py, logic [7:0] shd, int gap);
		logic acc;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		pix_x <= px;
		pix_y <= py;
		shade <= shd;
		do begin
			@(negedge clk);
			acc = !busy;
			@(posedge clk);
		end while (!acc);
		sb.note_pixel(px, py, shd);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending_rgb.size() != 0) @(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	task automatic random_pixels(int n);
		int gap;
		for (int i = 0; i < n; i++) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 0;
			if (i % 60 >= 40) gap = 0;
			send_pixel(10'($urandom), 10'($urandom), 8'($urandom), gap);
		end
	endtask

	initial begin
		sb = new();
		sb.reset_frame();
		arst_n = 0; start = 0; cfg_valid = 0; cfg_addr = CFG_LEFT; cfg_wdata = 0;
		pix_x = 0; pix_y = 0; shade = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset frame: centre gives both operands zero, edges give the axis cases
		send_pixel(10'd512, 10'd512, 8'd255, 0);
		send_pixel(10'd512, 10'd0, 8'd255, 0);
		send_pixel(10'd512, 10'd1023, 8'd255, 0);
		send_pixel(10'd0, 10'd512, 8'd255, 1);
		send_pixel(10'd1023, 10'd512, 8'd255, 0);
		send_pixel(10'd0, 10'd0, 8'd0, 0);
		send_pixel(10'd1023, 10'd1023, 8'd255, 2);
		send_pixel(10'd1023, 10'd0, 8'd170, 0);
		send_pixel(10'd0, 10'd1023, 8'd85, 0);
		drain();

		// zero divisor, oversize divisor, extreme edges
		set_frame(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'd0, 16'd2047);
		send_pixel(10'd0, 10'd0, 8'd255, 0);
		send_pixel(10'd1023, 10'd1023, 8'd255, 0);
		send_pixel(10'd1, 10'd1023, 8'd128, 0);
		send_pixel(10'd1023, 10'd1, 8'd1, 3);
		drain();
		set_frame(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'd1, 16'd1024);
		send_pixel(10'd1023, 10'd1023, 8'd255, 0);
		send_pixel(10'd0, 10'd0, 8'd255, 0);
		send_pixel(10'd1, 10'd0, 8'd200, 0);
		drain();

		set_frame(16'd0, 16'd0, 16'd4096, 16'd4096, 16'd1024, 16'd1024);
		random_pixels(200);
		drain();
		set_frame(16'hE000, 16'hE000, 16'd8192, 16'd8192, 16'd640, 16'd480);
		random_pixels(200);
		drain();
		set_frame(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'd1024, 16'd1024);
		random_pixels(150);
		drain();
		set_frame(16'd2048, 16'd2048, 16'd2048, 16'd2048, 16'd0, 16'd0);
		random_pixels(100);
		drain();
		for (int p = 0; p < 5; p++) begin
			set_frame(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom_range(0, 2047)), 16'($urandom_range(0, 2047)));
			random_pixels(160);
			drain();
		end

		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
